// ===== hdl/kle_pkg.sv =====
// shared constants, types and command/status structs of the line editor
package kle_pkg;

   localparam int LINE_CAPACITY = 256;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int CMP_W         = (ADDR_W > 8) ? ADDR_W : 8;
   localparam int TAB_W         = 5;

   localparam logic [TAB_W-1:0] TAB_SPACES_RESET = TAB_W'(4);
   localparam logic [7:0]       CHAR_NUL         = 8'h00;
   localparam logic [7:0]       CHAR_BS          = 8'h08;
   localparam logic [7:0]       CHAR_TAB         = 8'h09;
   localparam logic [7:0]       CHAR_NL          = 8'h0A;
   localparam logic [7:0]       CHAR_SPACE       = 8'h20;
   localparam logic [7:0]       LENGTH_MAX       = 8'hFF;

   localparam logic [ADDR_W-1:0] FILL_LIMIT = ADDR_W'(LINE_CAPACITY - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TAB,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      KEY_NONE,
      KEY_NL,
      KEY_BS,
      KEY_PRINT,
      KEY_TAB,
      KEY_IGNORE
   } key_class_type;

   typedef enum logic [1:0] {
      ECHO_KEY,
      ECHO_BS,
      ECHO_TAB,
      ECHO_NL
   } echo_sel_type;

   typedef struct packed {
      logic         load;
      logic         clear_line;
      logic         close_line;
      logic         dec_fill;
      logic         write_key;
      logic         write_space;
      logic         load_tab;
      logic         echo_en;
      echo_sel_type echo_sel;
      logic         capture_read;
   } dp_cmd_type;

   typedef struct packed {
      logic          op;
      key_class_type key_class;
      logic          closed;
      logic          empty;
      logic          full;
      logic          tab_zero;
   } dp_status_type;

endpackage

// ===== hdl/kle_ram.sv =====
// generic single write port ram with registered read
module kle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kle_ctrl.sv =====
// controller state machine of the line editor
module kle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  kle_pkg::dp_status_type status,
   output kle_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   kle_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.echo_sel = kle_pkg::ECHO_KEY;
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      case (state_ff)
         kle_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = kle_pkg::ST_EXEC;
            end
         end
         kle_pkg::ST_EXEC: begin
            if (status.op) begin
               cmd.capture_read = 1'b1;
               state_in         = kle_pkg::ST_RESP;
            end else if (status.key_class != kle_pkg::KEY_NONE && status.closed) begin
               // fresh line: empty it first, then handle the key
               cmd.clear_line = 1'b1;
            end else begin
               state_in = kle_pkg::ST_RESP;
               case (status.key_class)
                  kle_pkg::KEY_NL: begin
                     cmd.close_line = 1'b1;
                     cmd.echo_en    = 1'b1;
                     cmd.echo_sel   = kle_pkg::ECHO_NL;
                  end
                  kle_pkg::KEY_BS: begin
                     if (!status.empty) begin
                        cmd.dec_fill = 1'b1;
                        cmd.echo_en  = 1'b1;
                        cmd.echo_sel = kle_pkg::ECHO_BS;
                     end
                  end
                  kle_pkg::KEY_PRINT: begin
                     if (!status.full) begin
                        cmd.write_key = 1'b1;
                        cmd.echo_en   = 1'b1;
                        cmd.echo_sel  = kle_pkg::ECHO_KEY;
                     end
                  end
                  kle_pkg::KEY_TAB: begin
                     cmd.load_tab = 1'b1;
                     cmd.echo_en  = 1'b1;
                     cmd.echo_sel = kle_pkg::ECHO_TAB;
                     state_in     = kle_pkg::ST_TAB;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kle_pkg::ST_TAB: begin
            if (status.tab_zero || status.full) begin
               state_in = kle_pkg::ST_RESP;
            end else begin
               cmd.write_space = 1'b1;
            end
         end
         kle_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = kle_pkg::ST_IDLE;
         end
         default: begin
            state_in = kle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/kle_dp.sv =====
// datapath of the line editor: fill count, tab counter, line store, result registers
module kle_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  kle_pkg::dp_cmd_type          cmd,
   output kle_pkg::dp_status_type       status,
   input  logic                         req_op,
   input  logic [7:0]                   req_key_char,
   input  logic [7:0]                   req_read_index,
   input  logic                         csr_wr_en,
   input  logic [kle_pkg::TAB_W-1:0]    csr_wr_data,
   output logic                         rsp_echo_valid,
   output logic [7:0]                   rsp_echo_char,
   output logic                         rsp_line_done,
   output logic [7:0]                   rsp_line_length,
   output logic [7:0]                   rsp_read_data
);

   // control state
   logic [kle_pkg::ADDR_W-1:0] fill_ff, fill_in;
   logic                       closed_ff, closed_in;
   logic [kle_pkg::TAB_W-1:0]  tab_spaces_ff, tab_spaces_in;
   // payload
   logic [kle_pkg::TAB_W-1:0]  tab_cnt_ff, tab_cnt_in;
   logic                       op_ff, op_in;
   logic [7:0]                 key_ff, key_in;
   logic [7:0]                 idx_ff, idx_in;
   logic                       echo_valid_ff, echo_valid_in;
   logic [7:0]                 echo_char_ff, echo_char_in;
   logic                       done_ff, done_in;
   logic [7:0]                 rdata_ff, rdata_in;

   logic                       ram_we;
   logic [7:0]                 ram_wdata;
   logic [7:0]                 ram_rdata;
   logic [kle_pkg::CMP_W-1:0]  idx_ext;
   logic [kle_pkg::CMP_W-1:0]  fill_ext;
   logic                       in_range;
   kle_pkg::key_class_type     key_class;

   // read address follows the index being loaded so the byte is ready in the exec cycle
   kle_ram #(
      .WIDTH(8),
      .DEPTH(kle_pkg::LINE_CAPACITY)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(fill_ff),
      .wr_data(ram_wdata),
      .rd_addr(kle_pkg::ADDR_W'(idx_in)),
      .rd_data(ram_rdata)
   );

   assign ram_we    = cmd.write_key | cmd.write_space;
   assign ram_wdata = cmd.write_key ? key_ff : kle_pkg::CHAR_SPACE;
   assign idx_ext   = kle_pkg::CMP_W'(idx_ff);
   assign fill_ext  = kle_pkg::CMP_W'(fill_ff);
   assign in_range  = (idx_ext < fill_ext);

   // key decode
   always_comb begin
      if (key_ff == kle_pkg::CHAR_NUL) begin
         key_class = kle_pkg::KEY_NONE;
      end else if (key_ff == kle_pkg::CHAR_NL) begin
         key_class = kle_pkg::KEY_NL;
      end else if (key_ff == kle_pkg::CHAR_BS) begin
         key_class = kle_pkg::KEY_BS;
      end else if (key_ff == kle_pkg::CHAR_TAB) begin
         key_class = kle_pkg::KEY_TAB;
      end else if (!key_ff[7] && key_ff >= kle_pkg::CHAR_SPACE) begin
         key_class = kle_pkg::KEY_PRINT;
      end else begin
         key_class = kle_pkg::KEY_IGNORE;
      end
   end

   always_comb begin
      status.op        = op_ff;
      status.key_class = key_class;
      status.closed    = closed_ff;
      status.empty     = (fill_ff == '0);
      status.full      = (fill_ff == kle_pkg::FILL_LIMIT);
      status.tab_zero  = (tab_cnt_ff == '0);
   end

   always_comb begin
      fill_in       = fill_ff;
      closed_in     = closed_ff;
      tab_spaces_in = csr_wr_en ? csr_wr_data : tab_spaces_ff;
      tab_cnt_in    = tab_cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      echo_valid_in = echo_valid_ff;
      echo_char_in  = echo_char_ff;
      done_in       = done_ff;
      rdata_in      = rdata_ff;

      if (cmd.load) begin
         op_in         = req_op;
         key_in        = req_key_char;
         idx_in        = req_read_index;
         echo_valid_in = 1'b0;
         echo_char_in  = kle_pkg::CHAR_NUL;
         done_in       = 1'b0;
         rdata_in      = 8'h00;
      end
      if (cmd.clear_line) begin
         fill_in   = '0;
         closed_in = 1'b0;
      end
      if (cmd.close_line) begin
         closed_in = 1'b1;
         done_in   = 1'b1;
      end
      if (cmd.dec_fill) begin
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.write_key) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.write_space) begin
         fill_in    = fill_ff + 1'b1;
         tab_cnt_in = tab_cnt_ff - 1'b1;
      end
      if (cmd.load_tab) begin
         tab_cnt_in = tab_spaces_ff;
      end
      if (cmd.echo_en) begin
         echo_valid_in = 1'b1;
         case (cmd.echo_sel)
            kle_pkg::ECHO_KEY: echo_char_in = key_ff;
            kle_pkg::ECHO_BS:  echo_char_in = kle_pkg::CHAR_BS;
            kle_pkg::ECHO_TAB: echo_char_in = kle_pkg::CHAR_TAB;
            kle_pkg::ECHO_NL:  echo_char_in = kle_pkg::CHAR_NL;
            default:           echo_char_in = kle_pkg::CHAR_NUL;
         endcase
      end
      if (cmd.capture_read) begin
         rdata_in = in_range ? ram_rdata : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         closed_ff     <= 1'b0;
         tab_spaces_ff <= kle_pkg::TAB_SPACES_RESET;
      end else begin
         fill_ff       <= fill_in;
         closed_ff     <= closed_in;
         tab_spaces_ff <= tab_spaces_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_cnt_ff    <= tab_cnt_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      echo_valid_ff <= echo_valid_in;
      echo_char_ff  <= echo_char_in;
      done_ff       <= done_in;
      rdata_ff      <= rdata_in;
   end

   assign rsp_echo_valid  = echo_valid_ff;
   assign rsp_echo_char   = echo_char_ff;
   assign rsp_line_done   = done_ff;
   assign rsp_line_length = (fill_ext > kle_pkg::CMP_W'(kle_pkg::LENGTH_MAX))
                            ? kle_pkg::LENGTH_MAX : 8'(fill_ext);
   assign rsp_read_data   = rdata_ff;

endmodule

// ===== hdl/keyboard_line_editor_top.sv =====
// top level of the keyboard line editor
//
// channel   ports                          handshake
// --------  -----------------------------  -----------------------------------
// request   req_op, req_key_char,          transaction taken when start && !busy
//           req_read_index
// response  rsp_echo_valid, rsp_echo_char, one cycle, marked by rsp_strobe
//           rsp_line_done, rsp_line_length,
//           rsp_read_data
// config    csr_wr_en, csr_wr_data         tab width written when csr_wr_en
//
// a transaction runs from the accepting cycle through the exec state to the strobe in the
// resp state; a nonzero key that opens a fresh line after a closed one first takes an extra
// exec pass that clears the line, and a tab goes through the tab state, which stores its
// spaces one by one through the single write port of the line store until the configured
// space count is stored or the line is full. busy is low again the cycle after the strobe.
// reset (synchronous, active high) empties the line, reopens it and sets tab width to 4;
// the line store itself is not cleared. the receiver cannot stall responses.
module keyboard_line_editor_top (
   input  logic                      clock,
   input  logic                      reset,
   // request transaction
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic [7:0]                req_key_char,
   input  logic [7:0]                req_read_index,
   // response transaction
   output logic                      rsp_strobe,
   output logic                      rsp_echo_valid,
   output logic [7:0]                rsp_echo_char,
   output logic                      rsp_line_done,
   output logic [7:0]                rsp_line_length,
   output logic [7:0]                rsp_read_data,
   // tab width register
   input  logic                      csr_wr_en,
   input  logic [kle_pkg::TAB_W-1:0] csr_wr_data
);

   // command and status between the state machine and the datapath
   kle_pkg::dp_cmd_type    cmd;
   kle_pkg::dp_status_type status;

   // sequencing: decode, fresh line, tab fill loop, response strobe
   kle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   // fill count, line store, tab counter and response registers
   kle_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_key_char   (req_key_char),
      .req_read_index (req_read_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_char  (rsp_echo_char),
      .rsp_line_done  (rsp_line_done),
      .rsp_line_length(rsp_line_length),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the keyboard line editor: directed key table, then random transactions
module testbench;

   // item kinds on req_op
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // last printable code and the longest line the store keeps
   localparam logic [7:0] PRINT_LAST = 8'h7F;
   localparam int         LINE_MAX   = kle_pkg::LINE_CAPACITY - 1;

   // a tab at width 31 is the slowest transaction, this covers it with margin
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int ITEM_TARGET  = 1050;
   localparam int PHASES       = 6;

   // one response transaction, field for field
   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic       line_done;
      logic [7:0] line_length;
      logic [7:0] read_data;
   } echo_rsp_type;

   localparam echo_rsp_type NO_ECHO = '0;

   // one row of the directed table; typed rows carry their expected response
   typedef struct packed {
      logic         op;
      logic [7:0]   key;
      logic [7:0]   idx;
      logic         typed;
      echo_rsp_type rsp;
   } key_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_op;
   logic [7:0]                  req_key_char;
   logic [7:0]                  req_read_index;
   logic                        rsp_strobe;
   logic                        rsp_echo_valid;
   logic [7:0]                  rsp_echo_char;
   logic                        rsp_line_done;
   logic [7:0]                  rsp_line_length;
   logic [7:0]                  rsp_read_data;
   logic                        csr_wr_en;
   logic [kle_pkg::TAB_W-1:0]   csr_wr_data;

   // own copy of the editor state, advanced at each accepted transaction
   logic [7:0]                  exp_line [kle_pkg::LINE_CAPACITY];
   int                          exp_fill;
   bit                          exp_closed;
   logic [kle_pkg::TAB_W-1:0]   exp_tab_spaces;

   echo_rsp_type                pending_echoes[$];
   int                          error_count;
   int                          counted_items;
   int                          cycle_count;
   bit                          idle_on;

   // directed part: empty line first, every code class, then a closed line and a fresh one
   key_row_type directed_rows [25] = '{
      '{OP_READ, kle_pkg::CHAR_NUL,   8'd0,  1'b1, NO_ECHO},   // read of an empty line
      '{OP_READ, 8'hFF,               8'hFF, 1'b1, NO_ECHO},   // highest index, still empty
      '{OP_KEY,  kle_pkg::CHAR_NUL,   8'h5A, 1'b1, NO_ECHO},   // no key at all
      '{OP_KEY,  kle_pkg::CHAR_BS,    8'd0,  1'b1, NO_ECHO},   // backspace on an empty line
      '{OP_KEY,  kle_pkg::CHAR_SPACE, 8'd0,  1'b0, NO_ECHO},   // lowest printable
      '{OP_KEY,  PRINT_LAST,          8'd0,  1'b0, NO_ECHO},   // highest printable
      '{OP_KEY,  8'h41,               8'hA5, 1'b0, NO_ECHO},
      '{OP_KEY,  8'h01,               8'd0,  1'b0, NO_ECHO},   // ignored control codes
      '{OP_KEY,  8'h1F,               8'd0,  1'b0, NO_ECHO},
      '{OP_KEY,  8'h80,               8'd0,  1'b0, NO_ECHO},   // upper half ignored
      '{OP_KEY,  8'hFF,               8'd0,  1'b0, NO_ECHO},
      '{OP_KEY,  kle_pkg::CHAR_TAB,   8'd0,  1'b0, NO_ECHO},   // four spaces at reset width
      '{OP_KEY,  kle_pkg::CHAR_BS,    8'd0,  1'b0, NO_ECHO},
      '{OP_READ, 8'hC3,               8'd0,  1'b0, NO_ECHO},
      '{OP_READ, 8'd0,                8'd6,  1'b0, NO_ECHO},   // one past the last byte
      '{OP_KEY,  kle_pkg::CHAR_NL,    8'd0,  1'b0, NO_ECHO},   // close the line
      '{OP_READ, 8'd0,                8'd1,  1'b0, NO_ECHO},   // closed line still readable
      '{OP_KEY,  kle_pkg::CHAR_NUL,   8'd0,  1'b0, NO_ECHO},   // no key keeps it closed
      '{OP_READ, 8'd0,                8'd2,  1'b0, NO_ECHO},
      '{OP_KEY,  kle_pkg::CHAR_NL,    8'd0,  1'b1,
        '{1'b1, kle_pkg::CHAR_NL, 1'b1, 8'd0, 8'd0}},   // newline on a closed line: empty line
      '{OP_KEY,  8'h07,               8'd0,  1'b0, NO_ECHO},   // ignored code opens a line
      '{OP_KEY,  kle_pkg::CHAR_BS,    8'd0,  1'b0, NO_ECHO},
      '{OP_KEY,  8'h0B,               8'd0,  1'b0, NO_ECHO},
      '{OP_KEY,  kle_pkg::CHAR_TAB,   8'd0,  1'b0, NO_ECHO},
      '{OP_KEY,  kle_pkg::CHAR_NL,    8'd0,  1'b0, NO_ECHO}
   };

   keyboard_line_editor_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key_char    (req_key_char),
      .req_read_index  (req_read_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_read_data   (rsp_read_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // edits the local line copy the way the block does and returns the response it owes
   function automatic echo_rsp_type edit_line(input logic op, input logic [7:0] key,
                                              input logic [7:0] idx);
      echo_rsp_type rsp;
      int           n;
      rsp = NO_ECHO;
      if (op == OP_READ) begin
         // only bytes below the fill are ever returned
         if (int'(idx) < exp_fill) rsp.read_data = exp_line[idx];
      end else if (key != kle_pkg::CHAR_NUL) begin
         // any real key after a newline starts over
         if (exp_closed) begin
            exp_fill   = 0;
            exp_closed = 1'b0;
         end
         if (key == kle_pkg::CHAR_NL) begin
            exp_closed     = 1'b1;
            rsp.line_done  = 1'b1;
            rsp.echo_valid = 1'b1;
            rsp.echo_char  = kle_pkg::CHAR_NL;
         end else if (key == kle_pkg::CHAR_BS) begin
            if (exp_fill > 0) begin
               exp_fill--;
               rsp.echo_valid = 1'b1;
               rsp.echo_char  = kle_pkg::CHAR_BS;
            end
         end else if (key >= kle_pkg::CHAR_SPACE && key <= PRINT_LAST) begin
            // dropped silently once the line is full
            if (exp_fill < LINE_MAX) begin
               exp_line[exp_fill] = key;
               exp_fill++;
               rsp.echo_valid = 1'b1;
               rsp.echo_char  = key;
            end
         end else if (key == kle_pkg::CHAR_TAB) begin
            // spaces up to the room left, the tab echoes regardless
            for (n = 0; n < int'(exp_tab_spaces); n++) begin
               if (exp_fill < LINE_MAX) begin
                  exp_line[exp_fill] = kle_pkg::CHAR_SPACE;
                  exp_fill++;
               end
            end
            rsp.echo_valid = 1'b1;
            rsp.echo_char  = kle_pkg::CHAR_TAB;
         end
      end
      rsp.line_length = (exp_fill > 255) ? kle_pkg::LENGTH_MAX : 8'(exp_fill);
      return rsp;
   endfunction

   // offers one transaction, with random idle cycles ahead of it, and records what it owes.
   // start is left high after acceptance so back-to-back transactions need no second write
   // to start in the same step; the next idle cycle or the drain lowers it
   task automatic send_item(input logic op, input logic [7:0] key, input logic [7:0] idx,
                            input logic typed, input echo_rsp_type typed_rsp);
      echo_rsp_type predicted;
      begin
         while (idle_on && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
         start          <= 1'b1;
         req_op         <= op;
         req_key_char   <= key;
         req_read_index <= idx;
         @(posedge clock);
         while (busy) @(posedge clock);
         // accepted at this edge
         predicted = edit_line(op, key, idx);
         pending_echoes.push_back(typed ? typed_rsp : predicted);
         counted_items++;
      end
   endtask

   // key transaction; the unused index is random so its bits still toggle
   task automatic send_key(input logic [7:0] key);
      send_item(OP_KEY, key, 8'($urandom_range(0, 255)), 1'b0, NO_ECHO);
   endtask

   // read transaction with a random, unused key code
   task automatic send_read(input logic [7:0] idx);
      send_item(OP_READ, 8'($urandom_range(0, 255)), idx, 1'b0, NO_ECHO);
   endtask

   // lets every owed response arrive, then waits quietly before touching the register
   task automatic wait_idle();
      begin
         start <= 1'b0;
         while (pending_echoes.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end
   endtask

   task automatic write_tab_spaces(input logic [kle_pkg::TAB_W-1:0] width);
      begin
         wait_idle();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= width;
         @(posedge clock);
         exp_tab_spaces = width;
         csr_wr_en <= 1'b0;
      end
   endtask

   // a typed line: mostly printables, some tabs, backspaces, reads and stray codes,
   // usually closed by a newline and read back afterwards
   task automatic type_line(input int keys);
      int i;
      int pick;
      int reads;
      begin
         for (i = 0; i < keys; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
               send_key(8'($urandom_range(32, 127)));
            else if (pick < 76)
               send_key(kle_pkg::CHAR_TAB);
            else if (pick < 86)
               send_key(kle_pkg::CHAR_BS);
            else if (pick < 94)
               send_read(8'($urandom_range(0, (exp_fill + 2 > 255) ? 255 : exp_fill + 2)));
            else
               send_key(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 99) < 85) send_key(kle_pkg::CHAR_NL);
         reads = $urandom_range(0, 3);
         for (i = 0; i < reads; i++)
            send_read(8'($urandom_range(0, (exp_fill > 254) ? 255 : exp_fill + 1)));
      end
   endtask

   // fills the line to the brim, then pushes on the full-line corner
   task automatic fill_line();
      int i;
      begin
         while (exp_fill < LINE_MAX || exp_closed) begin
            if ($urandom_range(0, 99) < 30) send_key(kle_pkg::CHAR_TAB);
            else send_key(8'($urandom_range(32, 127)));
         end
         for (i = 0; i < 3; i++) send_key(8'($urandom_range(32, 127)));   // dropped
         send_key(kle_pkg::CHAR_TAB);                                     // echo, no space
         send_read(8'hFE);
         send_read(8'hFF);
         send_read(8'($urandom_range(0, 255)));
         send_key(kle_pkg::CHAR_BS);
         send_key(8'($urandom_range(32, 127)));
         send_key(kle_pkg::CHAR_NL);
         send_read(8'($urandom_range(0, 255)));
      end
   endtask

   // fully random transactions, ignored codes included
   task automatic noise_burst(input int count);
      int i;
      begin
         for (i = 0; i < count; i++)
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0, NO_ECHO);
      end
   endtask

   // response checker: every strobe must match the oldest owed response
   always @(posedge clock) begin
      echo_rsp_type expected;
      if (!reset && rsp_strobe) begin
         if (pending_echoes.size() == 0) begin
            $error("response transaction with none expected");
            error_count++;
         end else begin
            expected = pending_echoes.pop_front();
            if (rsp_echo_valid !== expected.echo_valid) begin
               $error("echo_valid: expected %0d, got %0d", expected.echo_valid, rsp_echo_valid);
               error_count++;
            end
            if (rsp_echo_char !== expected.echo_char) begin
               $error("echo_char: expected %0d, got %0d", expected.echo_char, rsp_echo_char);
               error_count++;
            end
            if (rsp_line_done !== expected.line_done) begin
               $error("line_done: expected %0d, got %0d", expected.line_done, rsp_line_done);
               error_count++;
            end
            if (rsp_line_length !== expected.line_length) begin
               $error("line_length: expected %0d, got %0d",
                      expected.line_length, rsp_line_length);
               error_count++;
            end
            if (rsp_read_data !== expected.read_data) begin
               $error("read_data: expected %0d, got %0d", expected.read_data, rsp_read_data);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int                        row;
      int                        phase;
      int                        phase_first;
      int                        phase_quota;
      logic [kle_pkg::TAB_W-1:0] width;
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_KEY;
      req_key_char   = kle_pkg::CHAR_NUL;
      req_read_index = 8'd0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = kle_pkg::TAB_SPACES_RESET;
      counted_items  = 0;
      idle_on        = 1'b1;
      exp_fill       = 0;
      exp_closed     = 1'b0;
      exp_tab_spaces = kle_pkg::TAB_SPACES_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset tab width
      for (row = 0; row < 25; row++)
         send_item(directed_rows[row].op, directed_rows[row].key, directed_rows[row].idx,
                   directed_rows[row].typed, directed_rows[row].rsp);

      // random phases: tab width zero, the register maximum, the nominal maximum,
      // one, then random widths; the third phase runs with no idle cycles
      phase_quota = (ITEM_TARGET - counted_items) / PHASES;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       width = '0;
            1:       width = '1;
            2:       width = kle_pkg::TAB_W'(16);
            3:       width = kle_pkg::TAB_W'(1);
            default: width = kle_pkg::TAB_W'($urandom_range(0, 31));
         endcase
         write_tab_spaces(width);
         idle_on     = (phase != 2);
         phase_first = counted_items;
         if (width >= kle_pkg::TAB_W'(8)) fill_line();
         while (counted_items - phase_first < phase_quota) begin
            if ($urandom_range(0, 99) < 75) type_line($urandom_range(1, 40));
            else noise_burst($urandom_range(5, 20));
         end
      end
      idle_on = 1'b1;

      // drain, then allow for the slowest transaction to show up late
      start <= 1'b0;
      while (pending_echoes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== keyboard_line_editor_top.f =====
hdl/kle_pkg.sv
hdl/kle_ram.sv
hdl/kle_ctrl.sv
hdl/kle_dp.sv
hdl/keyboard_line_editor_top.sv
tb/sv/testbench.sv
